FILE: hdl/lpkt_pkg.sv
// Package for the linear probe key table: sizes, result codes and the
// command/status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package lpkt_pkg;

    // SLOTS must be a power of two so that the home entry is the low key bits.
    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 6;
    localparam int ENTRY_W  = KEY_W + HANDLE_W;

    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;     // capture the request and the home entry
        logic rd;       // read the current probe entry
        logic advance;  // step to the next entry with wrap
        logic finish;   // load the result register, write on insert
    } lpkt_cmd_t;

    typedef struct packed {
        logic stop;     // probe entry matches or is empty
        logic last;     // every entry has now been probed
        logic out_free; // result register can take a new result
    } lpkt_stat_t;

endpackage

`default_nettype wire

FILE: hdl/linear_probe_key_table_top.sv
// Linear probe key table, top level: 64-entry open-addressing table of
// 64-bit keys and 32-bit handles with linear probing.
// Usage:
//   The input channel (in_valid/in_ready) carries one request: req_type
//   (0 find, 1 insert), key and handle_in. The output channel
//   (out_valid/out_ready) returns one result per request: status, slot and
//   handle_out. Probing starts at the low key bits and walks forward with wrap.
//   A request runs from acceptance to the result register in P probes,
//   where P is the number of probes (1 to 64); each probe is one read of the
//   entry RAM followed by a compare. Lightly loaded tables need only
//   a few probes. One request is worked at a time; the block returns to idle
//   when the result is loaded and takes the next request there, even while
//   the previous result still waits on the output.
//   If the receiver stalls, a finished result waits in the compare step and
//   the table is not written until the result register frees up.
//   Reset clears all valid bits at once, so every entry reads as empty with a
//   zero handle; no clearing pass is needed and requests are taken right away.
// Depends on lpkt_pkg, lpkt_ctrl, lpkt_dp and lpkt_ram.
`default_nettype none

module linear_probe_key_table_top
    import lpkt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic                req_type,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [HANDLE_W-1:0] handle_in,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [1:0]          status,
    output      logic [SLOT_W-1:0]   slot,
    output      logic [HANDLE_W-1:0] handle_out
);

    lpkt_cmd_t  cmd;
    lpkt_stat_t stat;

    lpkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpkt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .key        (key),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot       (slot),
        .handle_out (handle_out),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

`default_nettype wire

FILE: hdl/lpkt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lpkt_ctrl.sv
// Controller of the linear probe key table: sequences request capture,
// probe reads, compares and result hand-off. Depends on lpkt_pkg.
`default_nettype none

module lpkt_ctrl
    import lpkt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire lpkt_stat_t stat,
    output      lpkt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_CHECK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.stop || stat.last)
                begin
                    // Hold the read data until the result register is free.
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lpkt_dp.sv
// Datapath of the linear probe key table: request registers, probe index,
// entry store with valid bits, compare logic and the result register.
// Depends on lpkt_pkg and lpkt_ram.
`default_nettype none

module lpkt_dp
    import lpkt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_type,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [HANDLE_W-1:0] handle_in,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [1:0]          status,
    output      logic [SLOT_W-1:0]   slot,
    output      logic [HANDLE_W-1:0] handle_out,
    input  wire lpkt_cmd_t           cmd,
    output      lpkt_stat_t          stat
);

    logic                type_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [SLOTS-1:0]    vld_reg;
    logic                vldq_reg;
    logic                out_valid_reg;
    status_t             status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [HANDLE_W-1:0] hout_reg;

    logic [ENTRY_W-1:0]  rdata;
    logic [KEY_W-1:0]    ent_key;
    logic [HANDLE_W-1:0] ent_handle;
    logic                hit;
    logic                empty;
    logic                we;
    logic [IDX_W-1:0]    idx_next;

    lpkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata ({key_reg, hin_reg}),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // An entry never written since reset reads as empty with a zero handle.
    assign ent_key    = vldq_reg ? rdata[ENTRY_W-1:HANDLE_W] : '0;
    assign ent_handle = vldq_reg ? rdata[HANDLE_W-1:0] : '0;
    assign hit        = (ent_key == key_reg);
    assign empty      = (ent_key == '0);
    assign we         = cmd.finish && !hit && empty && (type_reg == REQ_INSERT);
    assign idx_next   = (idx_reg == IDX_W'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    assign stat.stop     = hit || empty;
    assign stat.last     = (cnt_reg == IDX_W'(SLOTS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            key_reg  <= key;
            hin_reg  <= handle_in;
            idx_reg  <= key[IDX_W-1:0];
            cnt_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            vldq_reg <= vld_reg[idx_reg];
        end
        if (cmd.finish)
        begin
            if (hit)
            begin
                status_reg <= ST_FOUND;
                slot_reg   <= SLOT_W'(idx_reg);
                hout_reg   <= ent_handle;
            end
            else if (empty && (type_reg == REQ_INSERT))
            begin
                status_reg <= ST_INSERTED;
                slot_reg   <= SLOT_W'(idx_reg);
                hout_reg   <= hin_reg;
            end
            else if (empty)
            begin
                status_reg <= ST_ABSENT;
                slot_reg   <= '0;
                hout_reg   <= '0;
            end
            else
            begin
                status_reg <= ST_FULL;
                slot_reg   <= '0;
                hout_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign handle_out = hout_reg;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for linear_probe_key_table_top: directed and random find and
// insert requests, a scoreboard that mirrors the probed table, random idling on both sides.
// Depends on lpkt_pkg and the linear_probe_key_table_top RTL.
`timescale 1ns / 100ps

module testbench;
    import lpkt_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 300;
    localparam int DRAIN_CYCLES   = 160;
    localparam int MAX_PRINTED    = 100;

    typedef struct {
        status_t               status;
        logic [SLOT_W-1:0]     slot;
        logic [HANDLE_W-1:0]   handle;
    } outcome_t;

    // Mirrors the table contents and holds the outcomes still owed by the block.
    class key_table_scoreboard;
        logic [KEY_W-1:0]    table_keys [SLOTS];
        logic [HANDLE_W-1:0] table_handles [SLOTS];
        outcome_t            awaited_outcomes [$];
        int                  mismatches;

        function new();
            foreach (table_keys[i])
            begin
                table_keys[i]    = '0;
                table_handles[i] = '0;
            end
            mismatches = 0;
        endfunction

        task report(input string msg);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function int pending();
            return awaited_outcomes.size();
        endfunction

        // Walks the mirrored table exactly as the block probes it and queues the outcome.
        function void note_request(input logic rt, input logic [KEY_W-1:0] k,
                                   input logic [HANDLE_W-1:0] h);
            logic [IDX_W-1:0] pos;
            outcome_t         res;
            bit               done;
            pos  = k[IDX_W-1:0];
            done = 0;
            res  = '{ST_FULL, '0, '0};
            for (int n = 0; n < SLOTS && !done; n++)
            begin
                if (table_keys[pos] == k)
                begin
                    res  = '{ST_FOUND, SLOT_W'(pos), table_handles[pos]};
                    done = 1;
                end
                else if (table_keys[pos] == '0)
                begin
                    if (rt == REQ_INSERT)
                    begin
                        table_keys[pos]    = k;
                        table_handles[pos] = h;
                        res = '{ST_INSERTED, SLOT_W'(pos), h};
                    end
                    else
                        res = '{ST_ABSENT, '0, '0};
                    done = 1;
                end
                else
                    pos = pos + 1'b1;
            end
            awaited_outcomes.push_back(res);
        endfunction

        task check_result(input logic [1:0] st, input logic [SLOT_W-1:0] sl,
                          input logic [HANDLE_W-1:0] h);
            outcome_t exp;
            if (awaited_outcomes.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d slot=%0d handle=%h", st, sl, h));
                return;
            end
            exp = awaited_outcomes.pop_front();
            if (st !== exp.status)
                report($sformatf("status %0d, expected %s", st, exp.status.name()));
            if (sl !== exp.slot)
                report($sformatf("slot %0d, expected %0d", sl, exp.slot));
            if (h !== exp.handle)
                report($sformatf("handle %h, expected %h", h, exp.handle));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle_in;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle_out;

    key_table_scoreboard sb;
    logic [KEY_W-1:0]    used_keys [$];
    int                  results_seen;
    int                  cycles;
    bit                  sender_calm;
    bit                  held_off;

    linear_probe_key_table_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .key        (key),
        .handle_in  (handle_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot       (slot),
        .handle_out (handle_out)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, so valid stays high when the next request comes straight away.
    task automatic send_request(input logic rt, input logic [KEY_W-1:0] k,
                                input logic [HANDLE_W-1:0] h);
        while (!sender_calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rt;
        key       <= k;
        handle_in <= h;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rt, k, h);
        if (rt == REQ_INSERT)
            used_keys.push_back(k);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // New keys are often crowded onto a few home entries around the wrap point so that
    // probe chains grow long and cross from the last entry to the first.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: k[IDX_W-1:0] = IDX_W'(SLOTS - 4 + $urandom_range(0, 5));
            1: k = KEY_W'($urandom_range(1, 300));
            default: ;
        endcase
        return k;
    endfunction

    initial
    begin
        logic             rt;
        logic [KEY_W-1:0] k;
        int               pick;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_FIND;
        key          = '0;
        handle_in    = '0;
        results_seen = 0;
        cycles       = 0;
        sender_calm  = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: key zero matches the first empty entry and never writes.
        send_request(REQ_FIND,   '0, 32'h1234_5678);
        send_request(REQ_INSERT, '0, '1);
        send_request(REQ_FIND,   64'd5, '0);
        send_request(REQ_INSERT, '1, '1);
        // Home entry is the last one, so this insert wraps to entry zero.
        send_request(REQ_INSERT, 64'h8000_0000_0000_003F, '0);
        // Hit on insert keeps the stored handle.
        send_request(REQ_INSERT, '1, 32'h1234_5678);
        send_request(REQ_FIND,   '1, '0);
        send_request(REQ_FIND,   64'h8000_0000_0000_003F, '1);
        send_request(REQ_FIND,   '0, '0);
        send_request(REQ_INSERT, 64'h40, 32'hA5A5_A5A5);
        send_request(REQ_INSERT, 64'h1, 32'h5A5A_5A5A);
        send_request(REQ_FIND,   64'h41, '1);
        send_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_request(REQ_FIND,   64'h4000_0000_0000_0000, '0);
        send_request(REQ_INSERT, '0, 32'hFFFF_0000);
        send_request(REQ_FIND,   64'h5555_5555_5555_5555, '0);
        wait_for_results();

        // Inserts are kept rare so the table fills slowly and reaches full late in the run.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sender_calm = (i >= 600 && i < 800);
            if (i == 1000)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 40 && used_keys.size() > 0)
                k = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else if (pick < 45)
                k = '0;
            else
                k = fresh_key();
            rt = ($urandom_range(0, 99) < 12) ? REQ_INSERT : REQ_FIND;
            send_request(rt, k, $urandom);
        end
        sender_calm = 0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Receiver: random stalls, one calm stretch and one long hold-off that backs up the block.
    initial
    begin
        out_ready = 1'b0;
        held_off  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLD_AT_RESULT)
            begin
                out_ready <= 1'b0;
                held_off = 1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= (results_seen >= 600 && results_seen < 800)
                         || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(status, slot, handle_out);
            results_seen++;
        end
    end

endmodule

FILE: filelist.f
hdl/lpkt_pkg.sv
hdl/lpkt_ram.sv
hdl/lpkt_ctrl.sv
hdl/lpkt_dp.sv
hdl/linear_probe_key_table_top.sv
sim/testbench.sv
